>>> hdl/clas_pkg.sv
// Shared types and constants for the comparator layer and sublayer assignment block.
package clas_pkg;

   // Field widths fixed by the stream payloads.
   localparam int CHAN_W  = 6;
   localparam int IDX_W   = 5;
   localparam int TOTAL_W = 6;

   // Request payload: chan_low [5:0], chan_high [11:6], new_network [12].
   localparam int REQ_W       = 16;
   localparam int REQ_LO_LSB  = 0;
   localparam int REQ_HI_LSB  = 6;
   localparam int REQ_NEW_BIT = 12;

   // Response payload: layer_index [4:0], sublayer_index [9:5],
   // layer_total [15:10], overflow [16].
   localparam int RSP_W = 24;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD_HI,
      ST_LAYER,
      ST_WR_LO,
      ST_WR_HI,
      ST_SEARCH,
      ST_OVF_RD,
      ST_OVF_WR,
      ST_OUT
   } clas_state_type;

endpackage

>>> hdl/clas_ram.sv
// Generic single-write, single-read RAM with registered read data.
module clas_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/comparator_layer_and_sublayer_assign_core.sv
// A request reads both channel entries, chooses the layer, writes both channel entries
// and scans the open sublayers of that layer first-fit; when every sublayer is full,
// the span is merged into the last one. Then the result is offered.
// The core works on one comparator at a time; the first-fit scan reads one
// sublayer mask per cycle from the single read port of the span memory.
// Reset (synchronous) clears the channel and count valid bits, the layer count and
// the sequencer; span masks are never cleared because only opened entries are read.
module comparator_layer_and_sublayer_assign_core #(
   parameter int CHANNELS      = 64,
   parameter int MAX_LAYERS    = 32,
   parameter int MAX_SUBLAYERS = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // chan_low [5:0], chan_high [11:6], new_network [12], zero fill [15:13]
   input  logic [clas_pkg::REQ_W-1:0]  req_tdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // layer_index [4:0], sublayer_index [9:5], layer_total [15:10], overflow [16],
   // zero fill [23:17]
   output logic [clas_pkg::RSP_W-1:0]  rsp_tdata
);

   import clas_pkg::*;

   localparam int CW  = $clog2(CHANNELS);
   localparam int LW  = MAX_LAYERS > 1 ? $clog2(MAX_LAYERS) : 1;
   localparam int LVW = $clog2(MAX_LAYERS + 1);
   localparam int SW  = MAX_SUBLAYERS > 1 ? $clog2(MAX_SUBLAYERS) : 1;
   localparam int SCW = $clog2(MAX_SUBLAYERS + 1);
   localparam int MD  = MAX_LAYERS * MAX_SUBLAYERS;
   localparam int AW  = MD > 1 ? $clog2(MD) : 1;

   clas_state_type state_ff, state_in;

   logic [CW-1:0]       lo_ff, lo_in, hi_ff, hi_in;
   logic [LVW-1:0]      cl_a_ff, cl_a_in;
   logic [LW-1:0]       layer_ff, layer_in;
   logic                ovf_ff, ovf_in;
   logic [LVW-1:0]      layers_open_ff, layers_open_in;
   logic [CHANNELS-1:0] span_ff, span_in;
   logic [AW-1:0]       base_ff, base_in;
   logic [SCW-1:0]      count_ff, count_in;
   logic [SCW-1:0]      s_ff, s_in;
   logic                pend_ff, pend_in;
   logic [SW-1:0]       sub_ff, sub_in;
   logic [CHANNELS-1:0] cll_vld_ff, cll_vld_in;
   logic [MAX_LAYERS-1:0] cnt_vld_ff, cnt_vld_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]    rsp_data_ff, rsp_data_in;

   // Request decode: clamp both channels, then order them.
   logic [CHAN_W-1:0] raw_lo, raw_hi;
   logic [CW-1:0]     clamp_lo, clamp_hi, lo_sw, hi_sw;

   // Memory ports.
   logic [CW-1:0]       cll_rd_addr, cll_wr_addr;
   logic                cll_wr_en;
   logic [LVW-1:0]      cll_wr_data, cll_rd_data;
   logic [LW-1:0]       cnt_rd_addr;
   logic                cnt_wr_en;
   logic [SCW-1:0]      cnt_wr_data, cnt_rd_data;
   logic [AW-1:0]       spn_rd_addr, spn_wr_addr;
   logic                spn_wr_en;
   logic [CHANNELS-1:0] spn_wr_data, spn_rd_data;

   // Scan status.
   logic           issue, hit, miss_all, full, out_load;
   logic [LVW-1:0] cl_b, cl_max;

   assign raw_lo   = req_tdata[REQ_LO_LSB +: CHAN_W];
   assign raw_hi   = req_tdata[REQ_HI_LSB +: CHAN_W];
   assign clamp_lo = ((CHAN_W+1)'(raw_lo) >= (CHAN_W+1)'(CHANNELS)) ?
                     CW'(CHANNELS - 1) : CW'(raw_lo);
   assign clamp_hi = ((CHAN_W+1)'(raw_hi) >= (CHAN_W+1)'(CHANNELS)) ?
                     CW'(CHANNELS - 1) : CW'(raw_hi);
   assign lo_sw    = (clamp_hi < clamp_lo) ? clamp_hi : clamp_lo;
   assign hi_sw    = (clamp_hi < clamp_lo) ? clamp_lo : clamp_hi;

   assign issue    = (s_ff < count_ff);
   assign hit      = pend_ff && ((spn_rd_data & span_ff) == '0);
   assign miss_all = !pend_ff && !issue;
   assign full     = (count_ff >= SCW'(MAX_SUBLAYERS));
   assign out_load = !rsp_valid_ff || rsp_tready;

   assign cl_b   = cll_vld_ff[hi_ff] ? cll_rd_data : '0;
   assign cl_max = (cl_b > cl_a_ff) ? cl_b : cl_a_ff;

   clas_ram #(.WIDTH(LVW), .DEPTH(CHANNELS)) u_chan_ram (
      .clock   (clock),
      .wr_en   (cll_wr_en),
      .wr_addr (cll_wr_addr),
      .wr_data (cll_wr_data),
      .rd_addr (cll_rd_addr),
      .rd_data (cll_rd_data)
   );

   clas_ram #(.WIDTH(SCW), .DEPTH(MAX_LAYERS)) u_count_ram (
      .clock   (clock),
      .wr_en   (cnt_wr_en),
      .wr_addr (layer_ff),
      .wr_data (cnt_wr_data),
      .rd_addr (cnt_rd_addr),
      .rd_data (cnt_rd_data)
   );

   clas_ram #(.WIDTH(CHANNELS), .DEPTH(MD)) u_span_ram (
      .clock   (clock),
      .wr_en   (spn_wr_en),
      .wr_addr (spn_wr_addr),
      .wr_data (spn_wr_data),
      .rd_addr (spn_rd_addr),
      .rd_data (spn_rd_data)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_tvalid) state_in = ST_RD_HI;
         ST_RD_HI:  state_in = ST_LAYER;
         ST_LAYER:  state_in = ST_WR_LO;
         ST_WR_LO:  state_in = ST_WR_HI;
         ST_WR_HI:  state_in = ST_SEARCH;
         ST_SEARCH: begin
            if (hit) begin
               state_in = ST_OUT;
            end else if (miss_all) begin
               state_in = full ? ST_OVF_RD : ST_OUT;
            end
         end
         ST_OVF_RD: state_in = ST_OVF_WR;
         ST_OVF_WR: state_in = ST_OUT;
         ST_OUT:    if (out_load) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Memory and handshake controls.
   always_comb begin
      req_tready  = 1'b0;
      cll_rd_addr = lo_ff;
      cll_wr_en   = 1'b0;
      cll_wr_addr = lo_ff;
      cll_wr_data = LVW'(layer_ff) + LVW'(1);
      cnt_rd_addr = layer_ff;
      cnt_wr_en   = 1'b0;
      cnt_wr_data = count_ff + SCW'(1);
      spn_rd_addr = base_ff + AW'(s_ff);
      spn_wr_en   = 1'b0;
      spn_wr_addr = base_ff + AW'(count_ff);
      spn_wr_data = span_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready  = 1'b1;
            cll_rd_addr = lo_sw;
         end
         ST_RD_HI: cll_rd_addr = hi_ff;
         ST_WR_LO: cll_wr_en = 1'b1;
         ST_WR_HI: begin
            cll_wr_en   = 1'b1;
            cll_wr_addr = hi_ff;
         end
         ST_SEARCH: begin
            if (hit) begin
               spn_wr_en   = 1'b1;
               spn_wr_addr = base_ff + AW'(s_ff - SCW'(1));
               spn_wr_data = spn_rd_data | span_ff;
            end else if (miss_all && !full) begin
               // Open a new sublayer holding just this span.
               spn_wr_en = 1'b1;
               cnt_wr_en = 1'b1;
            end
         end
         ST_OVF_RD: spn_rd_addr = base_ff + AW'(MAX_SUBLAYERS - 1);
         ST_OVF_WR: begin
            spn_wr_en   = 1'b1;
            spn_wr_addr = base_ff + AW'(MAX_SUBLAYERS - 1);
            spn_wr_data = spn_rd_data | span_ff;
         end
         ST_LAYER, ST_OUT: begin
         end
         default: begin
         end
      endcase
   end

   // Datapath register updates.
   always_comb begin
      lo_in          = lo_ff;
      hi_in          = hi_ff;
      cl_a_in        = cl_a_ff;
      layer_in       = layer_ff;
      ovf_in         = ovf_ff;
      layers_open_in = layers_open_ff;
      span_in        = span_ff;
      base_in        = base_ff;
      count_in       = count_ff;
      s_in           = s_ff;
      pend_in        = pend_ff;
      sub_in         = sub_ff;
      cll_vld_in     = cll_vld_ff;
      cnt_vld_in     = cnt_vld_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_data_in    = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               lo_in  = lo_sw;
               hi_in  = hi_sw;
               ovf_in = 1'b0;
               if (req_tdata[REQ_NEW_BIT]) begin
                  cll_vld_in     = '0;
                  cnt_vld_in     = '0;
                  layers_open_in = '0;
               end
            end
         end
         ST_RD_HI: cl_a_in = cll_vld_ff[lo_ff] ? cll_rd_data : '0;
         ST_LAYER: begin
            if (cl_max >= LVW'(MAX_LAYERS)) begin
               layer_in = LW'(MAX_LAYERS - 1);
               ovf_in   = 1'b1;
            end else begin
               layer_in = LW'(cl_max);
            end
            for (int i = 0; i < CHANNELS; i++) begin
               span_in[i] = (CW'(i) >= lo_ff) && (CW'(i) <= hi_ff);
            end
         end
         ST_WR_LO: begin
            if (LVW'(layer_ff) >= layers_open_ff) begin
               layers_open_in = LVW'(layer_ff) + LVW'(1);
            end
            base_in           = AW'(layer_ff * MAX_SUBLAYERS);
            cll_vld_in[lo_ff] = 1'b1;
         end
         ST_WR_HI: begin
            cll_vld_in[hi_ff] = 1'b1;
            count_in          = cnt_vld_ff[layer_ff] ? cnt_rd_data : '0;
            s_in              = '0;
            pend_in           = 1'b0;
         end
         ST_SEARCH: begin
            if (hit) begin
               sub_in = SW'(s_ff - SCW'(1));
            end else if (miss_all) begin
               if (full) begin
                  sub_in = SW'(MAX_SUBLAYERS - 1);
                  ovf_in = 1'b1;
               end else begin
                  sub_in               = SW'(count_ff);
                  cnt_vld_in[layer_ff] = 1'b1;
               end
            end else begin
               // Mask data for the previous index arrives while the next is read.
               pend_in = issue;
               if (issue) begin
                  s_in = s_ff + SCW'(1);
               end
            end
         end
         ST_OUT: begin
            if (out_load) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_W'({ovf_ff,
                                      TOTAL_W'({{TOTAL_W{1'b0}}, layers_open_ff}),
                                      IDX_W'({{IDX_W{1'b0}}, sub_ff}),
                                      IDX_W'({{IDX_W{1'b0}}, layer_ff})});
            end
         end
         ST_OVF_RD, ST_OVF_WR: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         layers_open_ff <= '0;
         cll_vld_ff     <= '0;
         cnt_vld_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         layers_open_ff <= layers_open_in;
         cll_vld_ff     <= cll_vld_in;
         cnt_vld_ff     <= cnt_vld_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      cl_a_ff     <= cl_a_in;
      layer_ff    <= layer_in;
      ovf_ff      <= ovf_in;
      span_ff     <= span_in;
      base_ff     <= base_in;
      count_ff    <= count_in;
      s_ff        <= s_in;
      pend_ff     <= pend_in;
      sub_ff      <= sub_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

>>> hdl/clas_checker.sv
// Port-level checker for the layer assignment core, with its bind statement.
module clas_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_tvalid,
   input logic                       req_tready,
   input logic                       rsp_tvalid,
   input logic                       rsp_tready,
   input logic [clas_pkg::RSP_W-1:0] rsp_tdata
);

   import clas_pkg::*;

   // A stalled result keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // The core works on one comparator at a time.
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while a comparator is in progress");

   // A new result is only produced at the end of a busy period.
   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result appeared without work in progress");

   // The assigned layer always lies below the running layer count.
   a_layer_below_total: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[15:10] != '0) |->
      ({1'b0, rsp_tdata[4:0]} < rsp_tdata[15:10]))
      else $error("layer index not below layer total");

endmodule

bind comparator_layer_and_sublayer_assign_core clas_checker u_clas_checker (.*);
